@@ src/bom_sniff_utf8_to_utf16_decoder_defines.svh @@
// assertion macros shared by the decoder rtl
`ifndef BOM_SNIFF_UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define BOM_SNIFF_UTF8_TO_UTF16_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSU_ASSERT(lbl, prop, msg)
`define BSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/bsu16_pkg.sv @@
// shared types and constants of the bom sniffing utf-8 to utf-16 decoder
package bsu16_pkg;

    localparam int MaxResults = 3;
    localparam int QueueDepth = 4;
    localparam int QueueCntW  = $clog2(QueueDepth + 1);
    localparam int ResCntW    = $clog2(MaxResults + 1);

    typedef enum logic [2:0] {
        PH_DETECT,
        PH_UTF8,
        PH_U16N,
        PH_U16S,
        PH_SWALLOW
    } phase_t;

    localparam logic [1:0] ENC_UTF8 = 2'd0;
    localparam logic [1:0] ENC_U16N = 2'd1;
    localparam logic [1:0] ENC_U16S = 2'd2;

    localparam logic [1:0] END_INPUT = 2'd0;
    localparam logic [1:0] END_ZERO  = 2'd1;
    localparam logic [1:0] END_TRUNC = 2'd2;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] hdr;
        logic [1:0]  hdr_cnt;
        logic [15:0] acc;
        logic [2:0]  rem;
        logic [7:0]  held;
        logic        held_valid;
    } dec_state_t;

    localparam dec_state_t StateInit = '{
        phase:      PH_DETECT,
        hdr:        16'd0,
        hdr_cnt:    2'd0,
        acc:        16'd0,
        rem:        3'd0,
        held:       8'd0,
        held_valid: 1'b0
    };

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        last;
        logic [1:0]  end_reason;
        logic [1:0]  encoding_found;
    } result_t;

    typedef struct packed {
        logic [ResCntW-1:0]         n;
        result_t [MaxResults-1:0]   res;
    } step_res_t;

endpackage

@@ src/bsu16_step.sv @@
// per-byte decode logic: next state and up to three results for one item
module bsu16_step
    import bsu16_pkg::*;
(
    input  dec_state_t cur,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    input  logic       host_big_endian,
    output dec_state_t nxt,
    output step_res_t  results
);

    localparam logic [7:0] BYTE_EF = 8'hef;
    localparam logic [7:0] BYTE_BB = 8'hbb;
    localparam logic [7:0] BYTE_BF = 8'hbf;
    localparam logic [7:0] BYTE_FE = 8'hfe;
    localparam logic [7:0] BYTE_FF = 8'hff;

    function automatic logic [1:0] enc_of(input phase_t ph);
        logic [1:0] e;
        e = ENC_UTF8;
        if (ph == PH_U16N) e = ENC_U16N;
        if (ph == PH_U16S) e = ENC_U16S;
        return e;
    endfunction

    function automatic void put(inout step_res_t r, input logic [15:0] unit,
                                input logic valid, input logic last,
                                input logic [1:0] reason, input phase_t ph);
        result_t item;
        item.code_unit      = unit;
        item.unit_valid     = valid;
        item.last           = last;
        item.end_reason     = reason;
        item.encoding_found = enc_of(ph);
        r.res[r.n[1:0]] = item;
        r.n = r.n + ResCntW'(1);
    endfunction

    function automatic void emit(inout dec_state_t st, inout step_res_t r,
                                 input logic [15:0] unit);
        put(r, unit, 1'b1, 1'b0, END_INPUT, st.phase);
        if (unit == 16'd0)
        begin
            put(r, 16'd0, 1'b0, 1'b1, END_ZERO, st.phase);
            st.phase = PH_SWALLOW;
        end
    endfunction

    function automatic void feed(inout dec_state_t st, inout step_res_t r,
                                 input logic [7:0] b);
        logic [2:0] rem_lead;
        logic [7:0] mask;
        rem_lead = 3'd0;
        mask     = 8'h00;
        if (st.phase == PH_UTF8)
        begin
            if (st.rem != 3'd0)
            begin
                st.acc = {st.acc[9:0], b[5:0]};
                st.rem = st.rem - 3'd1;
                if (st.rem == 3'd0)
                    emit(st, r, st.acc);
            end
            else
            begin
                unique casez (b)
                    8'b0???????: begin rem_lead = 3'd0; mask = 8'h7f; end
                    8'b110?????: begin rem_lead = 3'd1; mask = 8'h1f; end
                    8'b1110????: begin rem_lead = 3'd2; mask = 8'h0f; end
                    8'b11110???: begin rem_lead = 3'd3; mask = 8'h07; end
                    8'b111110??: begin rem_lead = 3'd4; mask = 8'h03; end
                    8'b1111110?: begin rem_lead = 3'd5; mask = 8'h01; end
                    default:     begin rem_lead = 3'd0; mask = 8'h00; end
                endcase
                st.acc = {8'd0, b & mask};
                if (rem_lead == 3'd0)
                    emit(st, r, st.acc);
                else
                    st.rem = rem_lead;
            end
        end
    endfunction

    // held mark bytes go back through the utf-8 path
    function automatic void replay(inout dec_state_t st, inout step_res_t r);
        logic [1:0] cnt;
        logic [15:0] hb;
        cnt = st.hdr_cnt;
        hb  = st.hdr;
        st.phase = PH_UTF8;
        if (cnt >= 2'd1)
            feed(st, r, hb[7:0]);
        if (cnt >= 2'd2)
            feed(st, r, hb[15:8]);
        st.hdr_cnt = 2'd0;
        st.hdr     = 16'd0;
    endfunction

    always_comb
    begin
        dec_state_t st;
        step_res_t  r;
        logic [7:0] b;
        logic [7:0] h0;
        logic       low_first;
        logic [1:0] reason;
        st = cur;
        r  = '0;
        b  = data_byte;
        h0 = cur.hdr[7:0];
        low_first = 1'b0;
        reason = END_INPUT;
        if (st.phase == PH_SWALLOW)
        begin
            if (end_of_file)
                st = StateInit;
        end
        else
        begin
            if (st.phase == PH_DETECT)
            begin
                case (st.hdr_cnt)
                    2'd0:
                    begin
                        if (b == BYTE_EF || b == BYTE_FF || b == BYTE_FE)
                        begin
                            st.hdr     = {8'd0, b};
                            st.hdr_cnt = 2'd1;
                        end
                        else
                        begin
                            st.phase = PH_UTF8;
                            feed(st, r, b);
                        end
                    end
                    2'd1:
                    begin
                        if (h0 == BYTE_FF && b == BYTE_FE)
                        begin
                            st.phase   = host_big_endian ? PH_U16S : PH_U16N;
                            st.hdr_cnt = 2'd0;
                            st.hdr     = 16'd0;
                        end
                        else if (h0 == BYTE_FE && b == BYTE_FF)
                        begin
                            st.phase   = host_big_endian ? PH_U16N : PH_U16S;
                            st.hdr_cnt = 2'd0;
                            st.hdr     = 16'd0;
                        end
                        else if (h0 == BYTE_EF && b == BYTE_BB)
                        begin
                            st.hdr[15:8] = b;
                            st.hdr_cnt   = 2'd2;
                        end
                        else
                        begin
                            replay(st, r);
                            feed(st, r, b);
                        end
                    end
                    default:
                    begin
                        if (b == BYTE_BF)
                        begin
                            st.phase   = PH_UTF8;
                            st.hdr_cnt = 2'd0;
                            st.hdr     = 16'd0;
                        end
                        else
                        begin
                            replay(st, r);
                            feed(st, r, b);
                        end
                    end
                endcase
                if (end_of_file && st.phase == PH_DETECT)
                    replay(st, r);
            end
            else if (st.phase == PH_UTF8)
            begin
                feed(st, r, b);
            end
            else
            begin
                if (st.held_valid)
                begin
                    low_first = (st.phase == PH_U16N) != host_big_endian;
                    put(r, low_first ? {b, st.held} : {st.held, b},
                        1'b1, 1'b0, END_INPUT, st.phase);
                    st.held_valid = 1'b0;
                    st.held       = 8'd0;
                end
                else
                begin
                    st.held       = b;
                    st.held_valid = 1'b1;
                end
            end
            if (end_of_file)
            begin
                if (st.phase != PH_SWALLOW)
                begin
                    if (st.phase == PH_UTF8 && st.rem != 3'd0)
                        reason = END_TRUNC;
                    if ((st.phase == PH_U16N || st.phase == PH_U16S) && st.held_valid)
                        reason = END_TRUNC;
                    put(r, 16'd0, 1'b0, 1'b1, reason, st.phase);
                end
                st = StateInit;
            end
        end
        nxt     = st;
        results = r;
    end

endmodule

@@ src/bsu16_queue.sv @@
// shift-register result queue, takes up to three results at once, gives one a cycle when popped
`include "bom_sniff_utf8_to_utf16_decoder_defines.svh"
module bsu16_queue
    import bsu16_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_en,
    input  step_res_t push,
    input  logic      pop,
    output result_t   head,
    output logic      not_empty,
    output logic      room
);

    result_t [QueueDepth-1:0] q_reg;
    result_t [QueueDepth-1:0] q_next;
    logic [QueueCntW-1:0]     count_reg;
    logic [QueueCntW-1:0]     count_next;
    logic [QueueCntW-1:0]     base;

    assign head      = q_reg[0];
    assign not_empty = (count_reg != '0);
    // room for one waiting result plus a full burst from the next item
    assign room      = (count_reg <= QueueCntW'(QueueDepth - MaxResults));

    always_comb
    begin
        q_next = q_reg;
        if (pop)
        begin
            for (int i = 0; i < QueueDepth - 1; i++)
                q_next[i] = q_reg[i+1];
        end
        base = count_reg - QueueCntW'(pop);
        for (int i = 0; i < QueueDepth; i++)
        begin
            for (int k = 0; k < MaxResults; k++)
            begin
                if (push_en && ResCntW'(k) < push.n &&
                    (base + QueueCntW'(k)) == QueueCntW'(i))
                    q_next[i] = push.res[k];
            end
        end
        count_next = base + (push_en ? QueueCntW'(push.n) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    `BSU_ASSERT(a_count_bound, count_reg <= QueueCntW'(QueueDepth),
        "result queue count beyond depth")
    `BSU_ASSERT(a_pop_drains,
        (pop && (!push_en || push.n == '0))
            |=> count_reg == QueueCntW'($past(count_reg) - QueueCntW'(1)),
        "pop without push did not drop count by one")
    `BSU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> count_reg == '0,
        "result queue not empty after reset")

endmodule

@@ src/bom_sniff_utf8_to_utf16_decoder.sv @@
// top level of the bom sniffing utf-8 / utf-16 to utf-16 decoder
// usage:
//   s_axis takes one file byte per item in s_axis_tdata[7:0], s_axis_tlast on
//   the final byte of a file. m_axis gives one result per item: the code unit
//   in m_axis_tdata, m_axis_tlast on the closing result of a file, and in
//   m_axis_tuser the unit-valid flag, end reason and detected encoding.
//   cfg_valid / cfg_data writes host_big_endian; cfg_ready is always high,
//   write it only while the block is idle.
// decode: a byte is decoded in the cycle it is accepted; its results are
//   registered in the result queue, whose head drives m_axis.
// throughput: one input item per cycle while m_axis_tready is high and each
//   byte gives at most one result; a byte that gives two or three results
//   (mark replay, zero unit, end of file) holds s_axis_tready low until at most
//   one result waits, results leaving one per cycle while m_axis_tready is high.
// reset: decoder returns to mark sniffing at start of file, the result queue
//   empties, host_big_endian clears.
// stall: when m_axis_tready is low results wait in a four-entry queue; input is
//   taken while at most one result is waiting, so one stalled result does not
//   block the next byte.
`include "bom_sniff_utf8_to_utf16_decoder_defines.svh"
module bom_sniff_utf8_to_utf16_decoder
    import bsu16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,        // host_big_endian
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [15:0] code_unit
    output logic        m_axis_tlast,    // last
    output logic [4:0]  m_axis_tuser     // [0] unit_valid, [2:1] end_reason,
                                         // [4:3] encoding_found
);

    // decoder state, advanced once per accepted byte
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       host_big_endian_reg;

    step_res_t  step_res;
    result_t    head;
    logic       accept;
    logic       pop;
    logic       q_room;
    logic       q_not_empty;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = q_room;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign pop           = m_axis_tvalid & m_axis_tready;

    // single-pass decode of the byte on the input port
    bsu16_step u_step (
        .cur             (state_reg),
        .data_byte       (s_axis_tdata),
        .end_of_file     (s_axis_tlast),
        .host_big_endian (host_big_endian_reg),
        .nxt             (state_next),
        .results         (step_res)
    );

    // results of one byte land together, leave one per cycle while m_axis_tready is high
    bsu16_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (step_res),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .room      (q_room)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= StateInit;
            host_big_endian_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                host_big_endian_reg <= cfg_data;
        end
    end

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = head.code_unit;
    assign m_axis_tlast  = head.last;
    assign m_axis_tuser  = {head.encoding_found, head.end_reason, head.unit_valid};

    // end of file always brings the decoder back to mark sniffing
    `BSU_ASSERT(a_eof_restart, (accept && s_axis_tlast) |=> (state_reg.phase == PH_DETECT && state_reg.hdr_cnt == 2'd0 && !state_reg.held_valid),
        "decoder not back at start of file after end of file")
    // a held odd byte exists only while decoding utf-16
    `BSU_ASSERT(a_held_u16, state_reg.held_valid |-> (state_reg.phase == PH_U16N || state_reg.phase == PH_U16S),
        "held byte outside utf-16 phase")

endmodule
